// ----- src/hvn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg: shared types and constants of the HID value normalizer
// Command codes, result kinds and the widths of the pipelined divider.
// ----------------------------------------------------------------------------
package hvn_pkg;

    // Command codes of the cmd input.
    typedef enum logic [1:0] {
        CMD_STICK   = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_HAT     = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // How the axis result is formed at the end of the pipe.
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_MIN  = 2'd1,
        KIND_MAX  = 2'd2,
        KIND_DIV  = 2'd3
    } kind_t;

    // Side information that travels with a beat through the divider.
    typedef struct packed {
        kind_t      kind;
        logic       neg;
        logic [3:0] dpad;
    } side_t;

    localparam int          AXIS_W          = 16;
    localparam int          QUOT_W          = 15;
    localparam int          REM_W           = 49;
    localparam int          HAT_LAST_POS    = 7;
    localparam logic [14:0] AXIS_FULL_SCALE = 15'd32767;
    localparam logic [14:0] THRESHOLD_RESET = 15'd1024;

endpackage

// ----- src/hid_value_normalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_value_normalizer: HID field value to gamepad axis, trigger or hat
// Pipeline: five front stages, a 15-stage restoring divider (one quotient bit a
// stage) and the output register lie between the start beat and the done
// strobe.
// Throughput: one beat per cycle; busy is always low, the result port cannot
// stall.
// Reset: rst_n clears all valid bits and loads threshold_reg with 1024.
// ----------------------------------------------------------------------------
module hid_value_normalizer
    import hvn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               cmd,
    input  logic [31:0]              raw_value,
    input  logic [5:0]               bit_size,
    input  logic signed [31:0]       logical_min,
    input  logic signed [31:0]       logical_max,
    input  logic                     cfg_wr_en,
    input  logic [14:0]              cfg_wr_data,
    output logic                     done,
    output logic signed [AXIS_W-1:0] axis_value,
    output logic [3:0]               dpad_bits,
    output logic                     non_neutral
);

    // The pipe runs as follows. Stage 1 decodes the raw value with optional
    // sign extension and forms n = value - min and d = max - min in 33 bits.
    // Stage 2 classifies the beat (empty range, clamped low or high, hat, or
    // a real division) and forms the signed numerator term 2n - d or n.
    // Stage 3 takes its magnitude, stage 4 multiplies by 32767 as a shift and
    // subtract, and stage 5 builds the rounding dividend 2 * 32767 * m + d.
    // Fifteen divider stages then resolve one quotient bit each against the
    // divisor 2d, and a final stage applies sign, clamps, the threshold
    // compare and drives the result ports.

    // The pipe never stalls, so a new beat is always welcome.
    assign busy = 1'b0;

    logic in_fire;
    assign in_fire = start && !busy;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [14:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode and differences
    // ------------------------------------------------------------------
    logic        do_ext;
    logic [4:0]  sign_idx;
    logic [31:0] keep_mask;
    logic [31:0] value_dec;
    logic [32:0] s1_n_next;
    logic [32:0] s1_d_next;

    always_comb
    begin
        do_ext    = logical_min[31] && (bit_size != 6'd0) && (bit_size < 6'd32);
        sign_idx  = 5'(bit_size - 6'd1);
        keep_mask = ~(32'hFFFF_FFFF << bit_size[4:0]);
        if (do_ext && raw_value[sign_idx])
        begin
            value_dec = raw_value | ~keep_mask;
        end
        else
        begin
            value_dec = raw_value;
        end
        s1_n_next = {value_dec[31], value_dec} - {logical_min[31], logical_min};
        s1_d_next = {logical_max[31], logical_max} - {logical_min[31], logical_min};
    end

    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [32:0] s1_n_reg;
    logic [32:0] s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd_t'(cmd);
        s1_n_reg   <= s1_n_next;
        s1_d_reg   <= s1_d_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: classification, hat decode and numerator term
    // ------------------------------------------------------------------
    logic        range_empty;
    logic        n_low;
    logic        n_high;
    logic        hat_hit;
    logic [3:0]  hat_dpad;
    side_t       s2_side_next;
    logic [34:0] s2_x_next;

    always_comb
    begin
        range_empty = s1_d_reg[32] || (s1_d_reg == '0);
        n_low       = s1_n_reg[32] || (s1_n_reg == '0);
        n_high      = $signed(s1_n_reg) >= $signed(s1_d_reg);
        hat_hit     = !s1_n_reg[32]
                      && (s1_n_reg[32:3] == '0)
                      && !($signed(s1_n_reg) > $signed(s1_d_reg));

        case (s1_n_reg[2:0])
            3'd0:    hat_dpad = 4'b0001;
            3'd1:    hat_dpad = 4'b0011;
            3'd2:    hat_dpad = 4'b0010;
            3'd3:    hat_dpad = 4'b0110;
            3'd4:    hat_dpad = 4'b0100;
            3'd5:    hat_dpad = 4'b1100;
            3'd6:    hat_dpad = 4'b1000;
            default: hat_dpad = 4'b1001;
        endcase

        s2_side_next.kind = KIND_ZERO;
        s2_side_next.neg  = 1'b0;
        s2_side_next.dpad = 4'b0000;

        case (s1_cmd_reg)
            CMD_STICK, CMD_TRIGGER:
            begin
                if (range_empty)
                begin
                    s2_side_next.kind = KIND_ZERO;
                end
                else if (n_low)
                begin
                    s2_side_next.kind = (s1_cmd_reg == CMD_STICK) ? KIND_MIN : KIND_ZERO;
                end
                else if (n_high)
                begin
                    s2_side_next.kind = KIND_MAX;
                end
                else
                begin
                    s2_side_next.kind = KIND_DIV;
                end
            end
            CMD_HAT:
            begin
                s2_side_next.dpad = hat_hit ? hat_dpad : 4'b0000;
            end
            default:
            begin
                s2_side_next.kind = KIND_ZERO;
            end
        endcase

        // The stick term is 2n - d; the trigger term is n itself.
        if (s1_cmd_reg == CMD_STICK)
        begin
            s2_x_next = {s1_n_reg[32], s1_n_reg, 1'b0} - {{2{s1_d_reg[32]}}, s1_d_reg};
        end
        else
        begin
            s2_x_next = {{2{s1_n_reg[32]}}, s1_n_reg};
        end
    end

    logic        s2_valid_reg;
    side_t       s2_side_reg;
    logic [34:0] s2_x_reg;
    logic [31:0] s2_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s2_x_reg    <= s2_x_next;
        s2_d_reg    <= s1_d_reg[31:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitude of the numerator term
    // ------------------------------------------------------------------
    logic [34:0] x_abs;
    side_t       s3_side_next;

    always_comb
    begin
        x_abs = s2_x_reg[34] ? (35'd0 - s2_x_reg) : s2_x_reg;
        s3_side_next     = s2_side_reg;
        s3_side_next.neg = s2_x_reg[34];
    end

    logic        s3_valid_reg;
    side_t       s3_side_reg;
    logic [31:0] s3_mag_reg;
    logic [31:0] s3_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= s3_side_next;
        s3_mag_reg  <= x_abs[31:0];
        s3_d_reg    <= s2_d_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: multiply by 32767 as (m << 15) - m
    // ------------------------------------------------------------------
    logic        s4_valid_reg;
    side_t       s4_side_reg;
    logic [46:0] s4_prod_reg;
    logic [31:0] s4_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_side_reg <= s3_side_reg;
        s4_prod_reg <= {s3_mag_reg, 15'd0} - {15'd0, s3_mag_reg};
        s4_d_reg    <= s3_d_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: rounding dividend 2 * product + d, loaded as divider entry
    // ------------------------------------------------------------------
    logic              div_valid_reg [0:QUOT_W];
    side_t             div_side_reg  [0:QUOT_W];
    logic [REM_W-1:0]  div_rem_reg   [0:QUOT_W];
    logic [QUOT_W-1:0] div_quot_reg  [0:QUOT_W];
    logic [31:0]       div_d_reg     [0:QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else
        begin
            div_valid_reg[0] <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_side_reg[0] <= s4_side_reg;
        div_rem_reg[0]  <= {1'b0, s4_prod_reg, 1'b0} + {17'd0, s4_d_reg};
        div_quot_reg[0] <= '0;
        div_d_reg[0]    <= s4_d_reg;
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage against the divisor 2d
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        localparam int BIT_POS = QUOT_W - 1 - k;

        logic [REM_W-1:0]  div_shifted;
        logic [REM_W:0]    trial;
        logic [REM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] quot_next;

        always_comb
        begin
            div_shifted = {16'd0, div_d_reg[k], 1'b0} << BIT_POS;
            trial       = {1'b0, div_rem_reg[k]} - {1'b0, div_shifted};
            quot_next   = div_quot_reg[k];
            if (!trial[REM_W])
            begin
                rem_next           = trial[REM_W-1:0];
                quot_next[BIT_POS] = 1'b1;
            end
            else
            begin
                rem_next = div_rem_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_side_reg[k+1] <= div_side_reg[k];
            div_rem_reg[k+1]  <= rem_next;
            div_quot_reg[k+1] <= quot_next;
            div_d_reg[k+1]    <= div_d_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: select result, apply sign, compare with threshold
    // ------------------------------------------------------------------
    side_t             out_side;
    logic [QUOT_W-1:0] out_mag;
    logic              out_neg;
    logic [AXIS_W-1:0] axis_next;
    logic              non_neutral_next;

    always_comb
    begin
        out_side = div_side_reg[QUOT_W];
        case (out_side.kind)
            KIND_MIN:
            begin
                out_mag = AXIS_FULL_SCALE;
                out_neg = 1'b1;
            end
            KIND_MAX:
            begin
                out_mag = AXIS_FULL_SCALE;
                out_neg = 1'b0;
            end
            KIND_DIV:
            begin
                out_mag = div_quot_reg[QUOT_W];
                out_neg = out_side.neg;
            end
            default:
            begin
                out_mag = '0;
                out_neg = 1'b0;
            end
        endcase
        axis_next = out_neg ? (AXIS_W'(0) - {1'b0, out_mag}) : {1'b0, out_mag};
        non_neutral_next = (out_mag > threshold_reg) || (out_side.dpad != 4'b0000);
    end

    logic                     done_reg;
    logic signed [AXIS_W-1:0] axis_value_reg;
    logic [3:0]               dpad_bits_reg;
    logic                     non_neutral_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        axis_value_reg  <= $signed(axis_next);
        dpad_bits_reg   <= out_side.dpad;
        non_neutral_reg <= non_neutral_next;
    end

    assign done        = done_reg;
    assign axis_value  = axis_value_reg;
    assign dpad_bits   = dpad_bits_reg;
    assign non_neutral = non_neutral_reg;

endmodule
